### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// Empty when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define SFTC_ASSERT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SFTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SFTC_ASSERT(label, ante, cons)
`define SFTC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/sftc_pkg.sv
// Shared constants, register indexes and the frame-bit function.
// No dependencies.
package sftc_pkg;

    localparam int unsigned BAUD_BITS       = 22;
    localparam int unsigned FRAME_BITS_W    = 4;
    localparam int unsigned CHAR_W          = 24;
    localparam int unsigned BURST_W         = 32;
    localparam int unsigned TURN_W          = 25;
    localparam int unsigned SIL_W           = 26;
    localparam int unsigned CFG_IDX_W       = 3;

    localparam int unsigned US_PER_SECOND   = 1000000;
    localparam int unsigned SIL_US_PER_BIT  = 3500000;  // 3.5 chars times 1e6 us per second
    localparam int unsigned FAST_BAUD_LIMIT = 19200;
    localparam int unsigned FAST_SILENCE_US = 1750;

    localparam logic [CFG_IDX_W-1:0] REG_BAUD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PARITY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO   = 3'd4;

    // Whole bit times per character from the clamped format.
    function automatic logic [FRAME_BITS_W-1:0] frame_bits(
        input logic [3:0] data_cnt,
        input logic       parity,
        input logic [2:0] stop_half
    );
        logic [3:0] d;
        logic [2:0] s;
        logic [4:0] half;
        d = data_cnt;
        s = stop_half;
        if (d < 4'd5) d = 4'd5;
        if (d > 4'd8) d = 4'd8;
        if (s < 3'd2) s = 3'd2;
        if (s > 3'd4) s = 3'd4;
        half = 5'd2 + {d, 1'b0} + {3'd0, parity, 1'b0} + {2'd0, s} + 5'd1;
        return half[4:1];
    endfunction

endpackage

### rtl/serial_frame_timing_calculator.sv
// Top level of the serial frame timing calculator.
// Depends on sftc_pkg, sftc_div_cell and assert_macros.svh.
//
// Takes a burst length (byte_count, low BURST_COUNT_BITS bits used) and returns,
// for the configured baud and frame format, the bit times per character, the
// character time, the burst time (saturating at 32 bits), the turnaround guard
// and the t3.5 silence, all in microseconds and rounded up. A new word can be
// taken every cycle while o_stall is low. Each word passes through the product
// stage, loaded by the accepting edge, then a numerator stage, one division
// cell per quotient bit of the widest numerator, and the output register.
// The whole pipe holds only while a result sits in the output register and the
// sink stalls. Configuration may be written only while no word is in flight;
// the output stage reads the live registers for baud, format and direction
// mode. A zero baud gives zero times; above 19200 baud the silence is 1750 us,
// and the turnaround guard is zero unless auto direction is set.
`include "assert_macros.svh"

module serial_frame_timing_calculator import sftc_pkg::*; #(
    parameter int unsigned BURST_COUNT_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [BAUD_BITS-1:0]    i_cfg_data,
    // request
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [15:0]             i_byte_count,
    // result
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [FRAME_BITS_W-1:0] o_frame_bits,
    output logic [CHAR_W-1:0]       o_char_time_us,
    output logic [BURST_W-1:0]      o_burst_time_us,
    output logic [TURN_W-1:0]       o_turnaround_us,
    output logic [SIL_W-1:0]        o_silence_us
);

    localparam int unsigned CW    = BURST_COUNT_BITS;
    localparam int unsigned PW    = CW + FRAME_BITS_W;  // bits * count
    localparam int unsigned NW    = PW + 20;            // times 1e6, fits 20 bits
    localparam int unsigned BURST = 1;
    localparam int unsigned CHAR  = 0;
    localparam int unsigned SIL   = 2;

    // ---- configuration registers ----
    logic [BAUD_BITS-1:0] r_baud;
    logic [3:0]           r_data_cnt;
    logic                 r_parity;
    logic [2:0]           r_stop_half;
    logic                 r_auto_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baud      <= BAUD_BITS'(9600);
            r_data_cnt  <= 4'd8;
            r_parity    <= 1'b0;
            r_stop_half <= 3'd2;
            r_auto_dir  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_BAUD:   r_baud      <= i_cfg_data;
                REG_DATA:   r_data_cnt  <= i_cfg_data[3:0];
                REG_PARITY: r_parity    <= i_cfg_data[0];
                REG_STOP:   r_stop_half <= i_cfg_data[2:0];
                REG_AUTO:   r_auto_dir  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [FRAME_BITS_W-1:0] w_bits;
    assign w_bits = frame_bits(r_data_cnt, r_parity, r_stop_half);

    // ---- flow control: whole pipe moves unless a result is held ----
    logic w_adv;
    logic r_o_valid;
    assign w_adv   = !(r_o_valid && i_stall);
    assign o_stall = !w_adv;

    // ---- stage 1: bits * count ----
    logic [CW+15:0] w_count_ext;
    logic [CW-1:0]  w_count;
    logic           r_s1_valid;
    logic [PW-1:0]  r_s1_prod;

    assign w_count_ext = {CW'(0), i_byte_count};
    assign w_count     = w_count_ext[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_prod <= PW'(w_bits) * PW'(w_count);
        end
    end

    // ---- stage 2: numerators; silence numerator is scaled by 3.5 ----
    logic                      r_s2_valid;
    logic [2:0][NW-1:0]        r_s2_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_num[BURST] <= NW'(r_s1_prod) * NW'(US_PER_SECOND);
            r_s2_num[CHAR]  <= NW'(w_bits) * NW'(US_PER_SECOND);
            r_s2_num[SIL]   <= NW'(w_bits) * NW'(SIL_US_PER_BIT);
        end
    end

    // ---- division chain: one cell per quotient bit ----
    logic                      w_vld [NW+1];
    logic [2:0][BAUD_BITS-1:0] w_rem [NW+1];
    logic [2:0][NW-1:0]        w_nq  [NW+1];

    assign w_vld[0] = r_s2_valid;
    assign w_rem[0] = '0;
    assign w_nq[0]  = r_s2_num;

    for (genvar g = 0; g < NW; g++) begin : g_cell
        sftc_div_cell #(
            .NUM_W (NW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_div   (r_baud),
            .i_valid (w_vld[g]),
            .i_rem   (w_rem[g]),
            .i_nq    (w_nq[g]),
            .o_valid (w_vld[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_nq    (w_nq[g+1])
        );
    end

    // ---- output stage: round up, saturate, special cases ----
    logic [2:0]     w_rnz;
    logic [NW:0]    w_burst_sum;
    logic [CHAR_W-1:0] w_char;
    logic [SIL_W-1:0]  w_sil;
    logic [BURST_W-1:0] w_burst;
    logic           w_baud_zero;
    logic           w_fast;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_rnz[l] = (w_rem[NW][l] != '0);
        end
    end

    assign w_baud_zero = (r_baud == '0);
    assign w_fast      = (r_baud > BAUD_BITS'(FAST_BAUD_LIMIT));
    assign w_char      = w_nq[NW][CHAR][CHAR_W-1:0] + CHAR_W'(w_rnz[CHAR]);
    assign w_sil       = w_nq[NW][SIL][SIL_W-1:0] + SIL_W'(w_rnz[SIL]);
    assign w_burst_sum = {1'b0, w_nq[NW][BURST]} + (NW+1)'(w_rnz[BURST]);
    assign w_burst     = (w_burst_sum[NW:BURST_W] != '0) ? '1
                       : w_burst_sum[BURST_W-1:0];

    logic [FRAME_BITS_W-1:0] r_frame_bits;
    logic [CHAR_W-1:0]       r_char;
    logic [BURST_W-1:0]      r_burst;
    logic [TURN_W-1:0]       r_turn;
    logic [SIL_W-1:0]        r_sil;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_o_valid <= w_vld[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_vld[NW]) begin
            r_frame_bits <= w_bits;
            if (w_baud_zero) begin
                r_char  <= '0;
                r_burst <= '0;
                r_turn  <= '0;
                r_sil   <= '0;
            end else begin
                r_char  <= w_char;
                r_burst <= w_burst;
                r_turn  <= r_auto_dir ? {w_char, 1'b0} : '0;
                r_sil   <= w_fast ? SIL_W'(FAST_SILENCE_US) : w_sil;
            end
        end
    end

    assign o_valid         = r_o_valid;
    assign o_frame_bits    = r_frame_bits;
    assign o_char_time_us  = r_char;
    assign o_burst_time_us = r_burst;
    assign o_turnaround_us = r_turn;
    assign o_silence_us    = r_sil;

    // ---- checks ----
    `SFTC_ASSERT(a_stall_needs_result, o_stall, o_valid)
    `SFTC_ASSERT(a_zero_baud, o_valid && w_baud_zero, {o_char_time_us, o_burst_time_us, o_silence_us} == '0)
    `SFTC_ASSERT(a_turn_needs_auto, o_valid && o_turnaround_us != '0, r_auto_dir)
    `SFTC_ASSERT(a_fast_silence, o_valid && w_fast, o_silence_us == SIL_W'(FAST_SILENCE_US))

endmodule

### rtl/sftc_div_cell.sv
// One restoring-division step for the three timing lanes.
// Depends on sftc_pkg.
module sftc_div_cell import sftc_pkg::*; #(
    parameter int unsigned NUM_W = 40
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic [BAUD_BITS-1:0]            i_div,
    input  logic                            i_valid,
    input  logic [2:0][BAUD_BITS-1:0]       i_rem,
    input  logic [2:0][NUM_W-1:0]           i_nq,
    output logic                            o_valid,
    output logic [2:0][BAUD_BITS-1:0]       o_rem,
    output logic [2:0][NUM_W-1:0]           o_nq
);

    logic [2:0][BAUD_BITS-1:0] n_rem;
    logic [2:0][NUM_W-1:0]     n_nq;
    logic                      r_valid;
    logic [2:0][BAUD_BITS-1:0] r_rem;
    logic [2:0][NUM_W-1:0]     r_nq;

    // Shift in the next numerator bit; the quotient bit fills from the bottom.
    always_comb begin
        logic [BAUD_BITS:0] sh;
        logic               ge;
        for (int l = 0; l < 3; l++) begin
            sh       = {i_rem[l], i_nq[l][NUM_W-1]};
            ge       = (sh >= {1'b0, i_div});
            n_rem[l] = ge ? BAUD_BITS'(sh - {1'b0, i_div}) : sh[BAUD_BITS-1:0];
            n_nq[l]  = {i_nq[l][NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_nq  <= n_nq;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_nq    = r_nq;

endmodule
